// ===== rtl/core/hsv_to_rgb_converter_macros.svh =====
// Assertion macros shared by the HSV to RGB converter RTL.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle, outside reset.
`define HSV2RGB_ASSERT_IMPLIES(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// Checks that a condition implies a consequence in the next cycle, outside reset.
`define HSV2RGB_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/hsv2rgb_pkg.sv =====
// Shared constants, types and helper functions of the HSV to RGB converter.
package hsv2rgb_pkg;

    // One 60 degree sector of hue in Q9.6 units.
    localparam int unsigned SECTOR_SPAN = 3840;
    // Number of hue sectors that can be tested before clamping (covers hue up to 32767).
    localparam int unsigned SECTOR_TESTS = 8;
    // Highest sector index after clamping.
    localparam logic [2:0] LAST_SECTOR = 3'd5;
    // Full scale of q and t terms, 255 * 256.
    localparam logic [23:0] FULL_Q16 = 24'd65280;
    // Reciprocal of 15 scaled by 2^16, exact for remainders below one sector.
    localparam logic [24:0] FRAC_RECIP = 25'd4370;
    // Reciprocal of 255 scaled by 2^23, exact for inputs up to 255 * 255.
    localparam logic [31:0] DIV255_RECIP = 32'd32897;

    // Destination of one shaded level.
    typedef enum logic [1:0] {
        SLOT_RED   = 2'd0,
        SLOT_GREEN = 2'd1,
        SLOT_BLUE  = 2'd2,
        SLOT_DROP  = 2'd3
    } t_slot;

    typedef t_slot t_route [6];

    // Six-sector routing tables for v, p, q and t.
    localparam t_route ROUTE_V = '{SLOT_RED, SLOT_GREEN, SLOT_GREEN,
                                   SLOT_BLUE, SLOT_BLUE, SLOT_RED};
    localparam t_route ROUTE_P = '{SLOT_BLUE, SLOT_BLUE, SLOT_RED,
                                   SLOT_RED, SLOT_GREEN, SLOT_GREEN};
    localparam t_route ROUTE_Q = '{SLOT_DROP, SLOT_RED, SLOT_DROP,
                                   SLOT_GREEN, SLOT_DROP, SLOT_BLUE};
    localparam t_route ROUTE_T = '{SLOT_GREEN, SLOT_DROP, SLOT_BLUE,
                                   SLOT_DROP, SLOT_RED, SLOT_DROP};

    // Truncating division by 255 through a reciprocal multiply.
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [31:0] prod;
        prod = {16'd0, x} * DIV255_RECIP;
        return prod[30:23];
    endfunction

    // Picks the level that the routing tables send to one channel.
    function automatic logic [7:0] route_pick(input logic [2:0] sec,
                                              input t_slot     chan,
                                              input logic [7:0] v,
                                              input logic [7:0] p,
                                              input logic [7:0] q,
                                              input logic [7:0] t);
        logic [7:0] res;
        res = 8'd0;
        if (ROUTE_V[sec] == chan) begin
            res = v;
        end else if (ROUTE_P[sec] == chan) begin
            res = p;
        end else if (ROUTE_Q[sec] == chan) begin
            res = q;
        end else if (ROUTE_T[sec] == chan) begin
            res = t;
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/hsv_to_rgb_converter.sv =====
// HSV to 8-bit RGB converter, a six-stage pipeline that takes one pixel per clock.
// Throughput: one request per cycle; o_busy is always low since the pipeline never stalls.
// Each request accepted at a clock edge passes through the six register stages, one multiplier
// deep, and then shows on the result ports with o_done high.
// Reset (i_rst_n low at a clock edge, synchronous) clears every stage valid bit; no
// result appears for requests that were in flight.
module hsv_to_rgb_converter (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [14:0] i_hue_deg,
    input  logic [7:0]  i_sat_level,
    input  logic [7:0]  i_val_level,
    output logic        o_done,
    output logic [7:0]  o_red_out,
    output logic [7:0]  o_green_out,
    output logic [7:0]  o_blue_out
);

    logic       accept;

    // Stage valid bits, one per pipeline register stage.
    logic [4:0] r_vld;
    logic       r_done;

    // Stage 1: sector count and remainder within the sector.
    logic [3:0]  r1_sec;
    logic [11:0] r1_rem;
    logic [7:0]  r1_s;
    logic [7:0]  r1_v;
    logic [3:0]  n1_sec;
    logic [11:0] n1_rem;

    // Stage 2: fraction, clamped sector and the p product.
    logic [2:0]  r2_sec;
    logic [7:0]  r2_f8;
    logic [7:0]  r2_s;
    logic [7:0]  r2_v;
    logic [15:0] r2_pp;
    logic [24:0] n2_frac;
    logic [15:0] n2_pp;

    // Stage 3: saturation times fraction terms and the finished p.
    logic [2:0]  r3_sec;
    logic [15:0] r3_sf;
    logic [15:0] r3_st;
    logic [7:0]  r3_s;
    logic [7:0]  r3_v;
    logic [7:0]  r3_p;
    logic [15:0] n3_sf;
    logic [15:0] n3_st;

    // Stage 4: value times the q and t numerators.
    logic [2:0]  r4_sec;
    logic [23:0] r4_yq;
    logic [23:0] r4_yt;
    logic        r4_grey;
    logic [7:0]  r4_v;
    logic [7:0]  r4_p;
    logic [23:0] n4_yq;
    logic [23:0] n4_yt;

    // Stage 5: finished q and t.
    logic [2:0]  r5_sec;
    logic        r5_grey;
    logic [7:0]  r5_v;
    logic [7:0]  r5_p;
    logic [7:0]  r5_q;
    logic [7:0]  r5_t;

    // Output registers.
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  n_red;
    logic [7:0]  n_green;
    logic [7:0]  n_blue;

    // The pipeline never holds a request off.
    assign o_busy = 1'b0;
    assign accept = i_start && !o_busy;

    // Sector by comparing against each sector boundary; the remainder removes that many spans.
    always_comb begin
        n1_sec = 4'd0;
        for (int k = 1; k <= int'(hsv2rgb_pkg::SECTOR_TESTS); k++) begin
            if (i_hue_deg >= 15'(k * hsv2rgb_pkg::SECTOR_SPAN)) begin
                n1_sec = n1_sec + 4'd1;
            end
        end
        n1_rem = 12'(i_hue_deg - 15'(n1_sec * hsv2rgb_pkg::SECTOR_SPAN));
    end

    // Fraction is the remainder divided by 15; p product uses 255 - s, which is ~s.
    assign n2_frac = {13'd0, r1_rem} * hsv2rgb_pkg::FRAC_RECIP;
    assign n2_pp   = {8'd0, r1_v} * {8'd0, ~r1_s};

    // Saturation scaled by the fraction and by its complement to 256.
    assign n3_sf = {8'd0, r2_s} * {8'd0, r2_f8};
    assign n3_st = {8'd0, r2_s} * (16'd256 - {8'd0, r2_f8});

    // Value times the numerators; both numerators stay non-negative.
    assign n4_yq = {16'd0, r3_v} * (hsv2rgb_pkg::FULL_Q16 - {8'd0, r3_sf});
    assign n4_yt = {16'd0, r3_v} * (hsv2rgb_pkg::FULL_Q16 - {8'd0, r3_st});

    // Route the four levels to the channels, or give grey when saturation is zero.
    always_comb begin
        if (r5_grey) begin
            n_red   = r5_v;
            n_green = r5_v;
            n_blue  = r5_v;
        end else begin
            n_red   = hsv2rgb_pkg::route_pick(r5_sec, hsv2rgb_pkg::SLOT_RED,
                                              r5_v, r5_p, r5_q, r5_t);
            n_green = hsv2rgb_pkg::route_pick(r5_sec, hsv2rgb_pkg::SLOT_GREEN,
                                              r5_v, r5_p, r5_q, r5_t);
            n_blue  = hsv2rgb_pkg::route_pick(r5_sec, hsv2rgb_pkg::SLOT_BLUE,
                                              r5_v, r5_p, r5_q, r5_t);
        end
    end

    // Valid bits move one stage per clock.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_done <= 1'b0;
        end else begin
            r_vld  <= {r_vld[3:0], accept};
            r_done <= r_vld[4];
        end
    end

    // Payload registers load every cycle; the valid bits say which are live.
    always_ff @(posedge i_clk) begin
        r1_sec  <= n1_sec;
        r1_rem  <= n1_rem;
        r1_s    <= i_sat_level;
        r1_v    <= i_val_level;

        r2_sec  <= (r1_sec > {1'b0, hsv2rgb_pkg::LAST_SECTOR}) ?
                   hsv2rgb_pkg::LAST_SECTOR : r1_sec[2:0];
        r2_f8   <= n2_frac[23:16];
        r2_s    <= r1_s;
        r2_v    <= r1_v;
        r2_pp   <= n2_pp;

        r3_sec  <= r2_sec;
        r3_sf   <= n3_sf;
        r3_st   <= n3_st;
        r3_s    <= r2_s;
        r3_v    <= r2_v;
        r3_p    <= hsv2rgb_pkg::div255(r2_pp);

        r4_sec  <= r3_sec;
        r4_yq   <= n4_yq;
        r4_yt   <= n4_yt;
        r4_grey <= (r3_s == 8'd0);
        r4_v    <= r3_v;
        r4_p    <= r3_p;

        // Division by 65280 is a shift by 8 and then a division by 255.
        r5_sec  <= r4_sec;
        r5_grey <= r4_grey;
        r5_v    <= r4_v;
        r5_p    <= r4_p;
        r5_q    <= hsv2rgb_pkg::div255(r4_yq[23:8]);
        r5_t    <= hsv2rgb_pkg::div255(r4_yt[23:8]);

        r_red   <= n_red;
        r_green <= n_green;
        r_blue  <= n_blue;
    end

    assign o_done      = r_done;
    assign o_red_out   = r_red;
    assign o_green_out = r_green;
    assign o_blue_out  = r_blue;

`include "hsv_to_rgb_converter_macros.svh"

    // A result strobe always traces back to an earlier request.
    `HSV2RGB_ASSERT_IMPLIES(a_done_has_request, i_clk, i_rst_n, o_done, $past(i_start, 6), "result without a request")

    // The value level always reaches one of the channels.
    `HSV2RGB_ASSERT_IMPLIES(a_value_routed, i_clk, i_rst_n, o_done, (o_red_out == $past(i_val_level, 6)) || (o_green_out == $past(i_val_level, 6)) || (o_blue_out == $past(i_val_level, 6)), "value level not routed")

    // Zero saturation gives equal channels.
    `HSV2RGB_ASSERT_IMPLIES(a_grey_equal, i_clk, i_rst_n, o_done && ($past(i_sat_level, 6) == 8'd0), (o_red_out == o_green_out) && (o_green_out == o_blue_out), "grey pixel has unequal channels")

    // The clamped sector entering stage 3 never exceeds the last sector.
    `HSV2RGB_ASSERT_NEXT(a_sector_clamped, i_clk, i_rst_n, r_vld[0], r2_sec <= hsv2rgb_pkg::LAST_SECTOR, "sector out of range after clamp")

endmodule
